/* sv/swer_pkg.sv */
// Shared constants and controller/datapath interface types for the event rate counter.
`default_nettype none

package swer_pkg;

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int WIN_W   = 32;
  localparam int RATE_W  = 34;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Window register reset value in milliseconds.
  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd30000;

  // 60000 ms per minute times 256 for the eight fraction bits.
  localparam int SCALE_W = 24;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 24'd15360000;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic apply;
    logic scan_start;
    logic scan_step;
    logic mult;
    logic div_start;
    logic div_step;
    logic load_out;
  } swer_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic div_done;
  } swer_sts_t;

endpackage

`default_nettype wire

/* sv/swer_ctrl.sv */
// Sequencing state machine for the event rate counter.
`default_nettype none

module swer_ctrl
  import swer_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  output logic           result_valid,
  input  wire logic      result_stall,
  output swer_cmd_t      cmd,
  input  wire swer_sts_t sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_APPLY = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_MULT  = 3'd4;
  localparam logic [2:0] ST_DIVS  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       result_valid_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        // The previous word must be gone before the output register is reloaded.
        if (!result_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.load_out) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

/* sv/swer_dp.sv */
// Datapath: stamp ring, window scan, rate multiply and serial divider.
`default_nettype none

module swer_dp
  import swer_pkg::*;
#(
  parameter int RING_DEPTH  = 1024,
  parameter int STAMP_WIDTH = 48,
  parameter int CNT_W       = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire swer_cmd_t              cmd,
  output swer_sts_t                   sts,
  input  wire logic                   cfg_we,
  input  wire logic [WIN_W-1:0]       cfg_data,
  input  wire logic [FUNC_W-1:0]      func,
  input  wire logic [STAMP_WIDTH-1:0] now_ms,
  output logic [CNT_W-1:0]            events_in_window,
  output logic [RATE_W-1:0]           rate_per_minute_q8
);

  localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CMP_W  = (STAMP_WIDTH > WIN_W) ? STAMP_WIDTH : WIN_W;
  localparam int NUM_W  = CNT_W + SCALE_W;
  localparam int DC_W   = $clog2(NUM_W + 1);
  localparam int Q_W    = (NUM_W > RATE_W) ? NUM_W : RATE_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_DEPTH);

  // Window register and latched item.
  logic [WIN_W-1:0]       window_ms;
  logic [FUNC_W-1:0]      func_r;
  logic [STAMP_WIDTH-1:0] now_r;

  // History state.
  logic [STAMP_WIDTH-1:0] ring [RING_DEPTH];
  logic [ADDR_W-1:0]      wp;
  logic [CNT_W-1:0]       stored;
  logic [STAMP_WIDTH-1:0] prev_stamp;
  logic                   prev_valid;

  // Scan state.
  logic [CNT_W-1:0]       idx;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   rd_pend;
  logic [STAMP_WIDTH-1:0] rd_data;
  logic [CNT_W-1:0]       acc;

  // Rate arithmetic.
  logic [NUM_W-1:0]       prod;
  logic [NUM_W-1:0]       num;
  logic [WIN_W-1:0]       rem;
  logic [DC_W-1:0]        div_cnt;

  logic [WIN_W-1:0]       win;
  logic                   backward;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   mem_we;
  logic                   issue;
  logic [STAMP_WIDTH-1:0] age;
  logic                   hit;
  logic [WIN_W:0]         trial;
  logic                   ge;
  logic [WIN_W:0]         diff;
  logic [Q_W-1:0]         quo;
  logic                   sat;

  // A zero window counts as one millisecond.
  assign win      = (window_ms == '0) ? WIN_W'(1) : window_ms;
  assign backward = prev_valid && (now_r < prev_stamp);
  assign wr_addr  = backward ? '0 : wp;
  assign mem_we   = cmd.apply && (func_r == FUNC_EVENT);
  assign issue    = cmd.scan_step && (idx < stored);
  assign age      = now_r - rd_data;
  assign hit      = (rd_data <= now_r) && (CMP_W'(age) < CMP_W'(win));
  assign trial    = {rem, num[NUM_W-1]};
  assign ge       = trial >= {1'b0, win};
  assign diff     = trial - {1'b0, win};
  assign quo      = Q_W'(num);
  assign sat      = quo > Q_W'(RATE_MAX);

  assign sts.scan_done = (idx == stored) && !rd_pend;
  assign sts.div_done  = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_addr] <= now_r;
    end
    if (issue) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms  <= WINDOW_RESET;
      wp         <= '0;
      stored     <= '0;
      prev_stamp <= '0;
      prev_valid <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_ms <= cfg_data;
      end
      if (cmd.apply) begin
        if (func_r == FUNC_EVENT) begin
          wp         <= (wr_addr == LAST_ADDR) ? '0 : wr_addr + 1'b1;
          stored     <= backward ? CNT_W'(1) :
                        (stored != FULL_CNT) ? stored + 1'b1 : stored;
          prev_stamp <= now_r;
          prev_valid <= 1'b1;
        end else if (func_r == FUNC_CLEAR) begin
          wp         <= '0;
          stored     <= '0;
          prev_stamp <= '0;
          prev_valid <= 1'b0;
        end
      end
      if (cmd.scan_start) begin
        rd_pend <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_pend <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r <= func;
      now_r  <= now_ms;
    end
    // Walk backward from the newest entry, one read per cycle.
    if (cmd.scan_start) begin
      idx     <= '0;
      rd_addr <= (wp == '0) ? LAST_ADDR : wp - 1'b1;
      acc     <= '0;
    end else if (cmd.scan_step) begin
      if (issue) begin
        idx     <= idx + 1'b1;
        rd_addr <= (rd_addr == '0) ? LAST_ADDR : rd_addr - 1'b1;
      end
      if (rd_pend && hit) begin
        acc <= acc + 1'b1;
      end
    end
    if (cmd.mult) begin
      prod <= NUM_W'(acc) * NUM_W'(RATE_SCALE);
    end
    // Restoring division, one quotient bit per cycle; quotient replaces num.
    if (cmd.div_start) begin
      num     <= prod;
      rem     <= '0;
      div_cnt <= DC_W'(NUM_W);
    end else if (cmd.div_step) begin
      rem     <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
      num     <= {num[NUM_W-2:0], ge};
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.load_out) begin
      events_in_window   <= acc;
      rate_per_minute_q8 <= sat ? RATE_MAX : quo[RATE_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/sliding_window_event_rate.sv */
// Top level of the sliding-window event rate counter.
//
// This block keeps the timestamps of the most recent RING_DEPTH events in an
// on-chip ring and answers every word it takes with one result word: the
// number of stored events whose stamps fall in (now_ms - window_ms, now_ms],
// and that count scaled to events per minute in unsigned Q8, truncated and
// saturated to the 34-bit field. An event word (func 0) stores its stamp,
// clearing the history first when the stamp is earlier than the previous
// event's; a clear word (func 2) empties the history; any other code is a
// plain query. One word is worked on at a time. The count is CNT_W bits
// wide (11 bits by default). The ring has a single read port and is read
// one entry per cycle for the window count, and the rate then comes from a
// restoring divider that yields one quotient bit per cycle. The ring needs
// no clearing pass after reset, since only entries written since the last
// clear are read. The result sits in an output register, so a new word is
// taken while the last result still waits. The window register is written
// through the cfg port, always ready, and should only change while no word
// is in progress; a window of zero acts as one.

`default_nettype none

module sliding_window_event_rate
  import swer_pkg::*;
#(
  parameter int RING_DEPTH  = 1024,
  parameter int STAMP_WIDTH = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Item channel.
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic [FUNC_W-1:0]                     func,
  input  wire logic [STAMP_WIDTH-1:0]                now_ms,
  // Result channel.
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic [$clog2(RING_DEPTH + 1)-1:0]          events_in_window,
  output logic [RATE_W-1:0]                          rate_per_minute_q8,
  // Window register write channel.
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [WIN_W-1:0]                      window_ms
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  swer_cmd_t cmd;
  swer_sts_t sts;

  // The register write never has to wait.
  assign cfg_ready = 1'b1;

  swer_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  swer_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .STAMP_WIDTH (STAMP_WIDTH),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_data           (window_ms),
    .func               (func),
    .now_ms             (now_ms),
    .events_in_window   (events_in_window),
    .rate_per_minute_q8 (rate_per_minute_q8)
  );

endmodule

`default_nettype wire
